>>> sv/dct_pkg.sv
// shared types, constants and register codes of the change range tracker
package dct_pkg;

  // default geometry
  localparam int DCT_CHANNELS  = 512;
  localparam int DCT_ZERO_HOLD = 8;

  // field widths
  localparam int LEVEL_W = 8;
  localparam int WIN_W   = 10;
  localparam int CHAN_W  = 9;
  localparam int TOTAL_W = 10;
  localparam int RUNS_W  = 9;
  localparam int OUT_DW  = 48;

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  // register reset values
  localparam logic             CHECK_NULL_RST   = 1'b1;
  localparam logic [WIN_W-1:0] WINDOW_FIRST_RST = 10'd1;
  localparam logic [WIN_W-1:0] WINDOW_LAST_RST  = 10'd512;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_CHECK_NULL   = 2'd0,
    REG_WINDOW_FIRST = 2'd1,
    REG_WINDOW_LAST  = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic             check_null;
    logic [WIN_W-1:0] window_first;
    logic [WIN_W-1:0] window_last;
  } cfg_t;

endpackage

>>> sv/dct_ram.sv
// generic single-write, single-read ram with registered read data
module dct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/dct_cfg.sv
// configuration registers behind the apb-style port
module dct_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dct_pkg::CFG_AW-1:0] paddr,
  input  logic [dct_pkg::CFG_DW-1:0] pwdata,
  output logic [dct_pkg::CFG_DW-1:0] prdata,
  output logic                       pready,
  output dct_pkg::cfg_t              cfg
);
  import dct_pkg::*;

  logic             check_null_r;
  logic [WIN_W-1:0] window_first_r;
  logic [WIN_W-1:0] window_last_r;
  logic             wr_en;
  cfg_reg_t         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = cfg_reg_t'(paddr[3:2]);

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      check_null_r   <= CHECK_NULL_RST;
      window_first_r <= WINDOW_FIRST_RST;
      window_last_r  <= WINDOW_LAST_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CHECK_NULL:   check_null_r   <= pwdata[0];
        REG_WINDOW_FIRST: window_first_r <= pwdata[WIN_W-1:0];
        REG_WINDOW_LAST:  window_last_r  <= pwdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_CHECK_NULL:   prdata = {{(CFG_DW-1){1'b0}}, check_null_r};
      REG_WINDOW_FIRST: prdata = {{(CFG_DW-WIN_W){1'b0}}, window_first_r};
      REG_WINDOW_LAST:  prdata = {{(CFG_DW-WIN_W){1'b0}}, window_last_r};
      default:          prdata = '0;
    endcase
  end

  assign cfg.check_null   = check_null_r;
  assign cfg.window_first = window_first_r;
  assign cfg.window_last  = window_last_r;

endmodule

>>> sv/dct_core.sv
// channel update stage: mark and hold logic, run tracking, result register
module dct_core #(
  parameter int CHANNELS  = dct_pkg::DCT_CHANNELS,
  parameter int ZERO_HOLD = dct_pkg::DCT_ZERO_HOLD,
  localparam int CHW = $clog2(CHANNELS),
  localparam int HW  = $clog2(ZERO_HOLD + 1),
  localparam int MW  = dct_pkg::LEVEL_W + 1 + HW
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dct_pkg::cfg_t               cfg,
  // accepted item and its channel
  input  logic                        in_accept,
  input  logic [CHW-1:0]              in_ch,
  input  logic [dct_pkg::LEVEL_W-1:0] in_level,
  output logic                        in_ready,
  // channel memory
  input  logic [MW-1:0]               mem_rdata,
  output logic                        mem_we,
  output logic [CHW-1:0]              mem_waddr,
  output logic [MW-1:0]               mem_wdata,
  // result side
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_range_valid,
  output logic                        out_frame_done,
  output logic [dct_pkg::CHAN_W-1:0]  out_range_first,
  output logic [dct_pkg::CHAN_W-1:0]  out_range_last,
  output logic [dct_pkg::TOTAL_W-1:0] out_total_bytes,
  output logic [dct_pkg::RUNS_W-1:0]  out_single_runs,
  output logic [dct_pkg::RUNS_W-1:0]  out_pack_runs
);
  import dct_pkg::*;

  localparam int CMPW = (CHW + 1 > WIN_W) ? CHW + 1 : WIN_W;
  localparam logic [CHW-1:0] LAST_CH = CHW'(CHANNELS - 1);
  localparam logic [HW-1:0]  HOLD    = HW'(ZERO_HOLD);

  // stage registers
  logic               s1_v_r;
  logic [CHW-1:0]     s1_ch_r;
  logic [LEVEL_W-1:0] s1_lvl_r;
  logic               byp_r;
  logic [MW-1:0]      byp_data_r;
  logic [CHW:0]       fill_r;

  // frame state
  logic               run_open_r;
  logic [CHW-1:0]     run_start_r;
  logic [CHW:0]       byte_tot_r;
  logic [CHW:0]       single_tot_r;
  logic [CHW:0]       pack_tot_r;

  // result register
  logic               out_v_r;
  logic               o_rv_r;
  logic               o_fd_r;
  logic [CHAN_W-1:0]  o_first_r;
  logic [CHAN_W-1:0]  o_last_r;
  logic [TOTAL_W-1:0] o_bytes_r;
  logic [RUNS_W-1:0]  o_single_r;
  logic [RUNS_W-1:0]  o_pack_r;

  // combinational
  logic               s1_go;
  logic               s1_fire;
  logic [MW-1:0]      old_word;
  logic [LEVEL_W-1:0] old_lvl;
  logic               old_mark;
  logic [HW-1:0]      old_cnt;
  logic [CMPW-1:0]    num;
  logic               in_win;
  logic               mark_a;
  logic               mark_nxt;
  logic [HW-1:0]      cnt_nxt;
  logic               first_ch;
  logic               is_last;
  logic               open_e;
  logic [CHW-1:0]     start_e;
  logic [CHW:0]       bytes_e;
  logic [CHW:0]       single_e;
  logic [CHW:0]       pack_e;
  logic               closing;
  logic [CHW-1:0]     close_last;
  logic [CHW:0]       run_len;
  logic               emit;
  logic               run_open_nxt;
  logic [CHW-1:0]     run_start_nxt;
  logic [CHW:0]       byte_tot_nxt;
  logic [CHW:0]       single_tot_nxt;
  logic [CHW:0]       pack_tot_nxt;
  logic [31:0]        first32;
  logic [31:0]        last32;
  logic [31:0]        bytes32;
  logic [31:0]        single32;
  logic [31:0]        pack32;

  assign s1_go    = !out_v_r || out_ready;
  assign s1_fire  = s1_v_r && s1_go;
  assign in_ready = !s1_v_r || s1_go;

  // stored entry: forwarded, read back, or reset value at or past the fill count
  always_comb begin
    if (byp_r) begin
      old_word = byp_data_r;
    end else if ({1'b0, s1_ch_r} < fill_r) begin
      old_word = mem_rdata;
    end else begin
      old_word = '0;
    end
  end
  assign {old_lvl, old_mark, old_cnt} = old_word;

  // change marking and zero hold
  assign num    = CMPW'(s1_ch_r) + CMPW'(1);
  assign in_win = (num >= CMPW'(cfg.window_first)) && (num <= CMPW'(cfg.window_last));
  assign mark_a = old_mark || (in_win && (old_lvl != s1_lvl_r));

  always_comb begin
    mark_nxt = mark_a;
    cnt_nxt  = old_cnt;
    if (mark_a) begin
      if (s1_lvl_r != '0) begin
        cnt_nxt = '0;
      end else if (old_cnt < HOLD) begin
        cnt_nxt = old_cnt + HW'(1);
      end else if (cfg.check_null) begin
        mark_nxt = 1'b0;
      end
    end
  end

  assign mem_we    = s1_fire;
  assign mem_waddr = s1_ch_r;
  assign mem_wdata = {s1_lvl_r, mark_nxt, cnt_nxt};

  // frame state as seen by this channel, cleared on channel zero
  assign first_ch = (s1_ch_r == '0);
  assign is_last  = (s1_ch_r == LAST_CH);
  assign open_e   = first_ch ? 1'b0 : run_open_r;
  assign start_e  = first_ch ? '0 : run_start_r;
  assign bytes_e  = first_ch ? '0 : byte_tot_r;
  assign single_e = first_ch ? '0 : single_tot_r;
  assign pack_e   = first_ch ? '0 : pack_tot_r;

  // run open and close
  always_comb begin
    run_open_nxt  = open_e;
    run_start_nxt = start_e;
    closing       = 1'b0;
    close_last    = s1_ch_r;
    if (mark_nxt) begin
      if (!open_e) begin
        run_open_nxt  = 1'b1;
        run_start_nxt = s1_ch_r;
      end
      if (is_last) begin
        closing = 1'b1;
      end
    end else if (open_e) begin
      closing    = 1'b1;
      close_last = s1_ch_r - CHW'(1);
    end
    if (closing) begin
      run_open_nxt = 1'b0;
    end
  end

  assign run_len = {1'b0, close_last} - {1'b0, run_start_nxt} + (CHW+1)'(1);

  // running totals
  always_comb begin
    byte_tot_nxt   = bytes_e;
    single_tot_nxt = single_e;
    pack_tot_nxt   = pack_e;
    if (closing) begin
      byte_tot_nxt = bytes_e + run_len;
      if (run_len == (CHW+1)'(1)) begin
        single_tot_nxt = single_e + (CHW+1)'(1);
      end else begin
        pack_tot_nxt = pack_e + (CHW+1)'(1);
      end
    end
  end

  assign emit = closing || is_last;

  // output fields masked to their widths
  assign first32  = closing ? 32'(run_start_nxt) : '0;
  assign last32   = closing ? 32'(close_last) : '0;
  assign bytes32  = 32'(byte_tot_nxt);
  assign single32 = 32'(single_tot_nxt);
  assign pack32   = 32'(pack_tot_nxt);

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_accept) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_ch_r    <= in_ch;
      s1_lvl_r   <= in_level;
      byp_r      <= s1_v_r && (s1_ch_r == in_ch);
      byp_data_r <= mem_wdata;
    end
  end

  // fill count and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r       <= '0;
      run_open_r   <= 1'b0;
      run_start_r  <= '0;
      byte_tot_r   <= '0;
      single_tot_r <= '0;
      pack_tot_r   <= '0;
    end else if (s1_fire) begin
      if ({1'b0, s1_ch_r} == fill_r) begin
        fill_r <= fill_r + (CHW+1)'(1);
      end
      run_open_r   <= run_open_nxt;
      run_start_r  <= run_start_nxt;
      byte_tot_r   <= byte_tot_nxt;
      single_tot_r <= single_tot_nxt;
      pack_tot_r   <= pack_tot_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_go) begin
      out_v_r <= s1_v_r && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      o_rv_r     <= closing;
      o_fd_r     <= is_last;
      o_first_r  <= first32[CHAN_W-1:0];
      o_last_r   <= last32[CHAN_W-1:0];
      o_bytes_r  <= bytes32[TOTAL_W-1:0];
      o_single_r <= single32[RUNS_W-1:0];
      o_pack_r   <= pack32[RUNS_W-1:0];
    end
  end

  assign out_valid       = out_v_r;
  assign out_range_valid = o_rv_r;
  assign out_frame_done  = o_fd_r;
  assign out_range_first = o_first_r;
  assign out_range_last  = o_last_r;
  assign out_total_bytes = o_bytes_r;
  assign out_single_runs = o_single_r;
  assign out_pack_runs   = o_pack_r;

`ifndef ASSERT_OFF
  // a stalled item keeps its channel
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && !s1_go |=> s1_v_r && $stable(s1_ch_r))
    else $error("stalled item lost its channel");

  // fill count never passes the channel count
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (CHW+1)'(CHANNELS))
    else $error("fill count beyond channel count");

  // channels are visited as a prefix: never beyond the fill count
  a_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> ({1'b0, s1_ch_r} <= fill_r))
    else $error("channel beyond fill count");

  // a forwarded entry only follows a write to the same channel
  a_bypass: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && s1_v_r |=> byp_r == ($past(s1_ch_r) == s1_ch_r))
    else $error("forwarding flag wrong");
`endif

endmodule

>>> sv/dct_change_range_tracker.sv
// top level of the change range tracker: channel counter, channel memory, stage and registers
// an accepted item is held in the input stage, then in the result register that drives out_tvalid
// throughput: one item per cycle unless a held result stalls the input stage; the channel memory is
// read on accept, written when the item leaves it, forwarded when the same channel follows directly
// reset (rst_n, synchronous) clears control state; channel memory needs no clearing
// pass, a fill count makes unwritten channels read as zero, so items are taken at once
module dmx_change_range_tracker #(
  parameter int CHANNELS  = dct_pkg::DCT_CHANNELS,
  parameter int ZERO_HOLD = dct_pkg::DCT_ZERO_HOLD
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] level
  input  logic                       in_tuser,   // [0] frame_start
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [dct_pkg::OUT_DW-1:0] out_tdata,  // [8:0] range_first, [17:9] range_last,
                                                 // [27:18] total_bytes, [36:28] single_runs,
                                                 // [45:37] pack_runs, [47:46] zero
  output logic                       out_tuser,  // [0] range_valid
  output logic                       out_tlast,  // frame_done
  // configuration port
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [dct_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [dct_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [dct_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import dct_pkg::*;

  localparam int CHW = $clog2(CHANNELS);
  localparam int HW  = $clog2(ZERO_HOLD + 1);
  localparam int MW  = LEVEL_W + 1 + HW;
  localparam logic [CHW-1:0] LAST_CH = CHW'(CHANNELS - 1);

  cfg_t           cfg;
  logic           accept;
  logic [CHW-1:0] pos_r;
  logic [CHW-1:0] pos_nxt;
  logic [CHW-1:0] ch_in;
  logic [MW-1:0]  mem_rdata;
  logic           mem_we;
  logic [CHW-1:0] mem_waddr;
  logic [MW-1:0]  mem_wdata;
  logic [CHAN_W-1:0]  range_first;
  logic [CHAN_W-1:0]  range_last;
  logic [TOTAL_W-1:0] total_bytes;
  logic [RUNS_W-1:0]  single_runs;
  logic [RUNS_W-1:0]  pack_runs;

  dct_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // channel counter, restarted by frame_start
  assign accept  = in_tvalid && in_tready;
  assign ch_in   = in_tuser ? '0 : pos_r;
  assign pos_nxt = (ch_in == LAST_CH) ? '0 : ch_in + CHW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  // per-channel level, mark and hold count
  dct_ram #(
    .WIDTH (MW),
    .DEPTH (CHANNELS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (ch_in),
    .rdata (mem_rdata)
  );

  dct_core #(
    .CHANNELS  (CHANNELS),
    .ZERO_HOLD (ZERO_HOLD)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .in_accept       (accept),
    .in_ch           (ch_in),
    .in_level        (in_tdata),
    .in_ready        (in_tready),
    .mem_rdata       (mem_rdata),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_range_valid (out_tuser),
    .out_frame_done  (out_tlast),
    .out_range_first (range_first),
    .out_range_last  (range_last),
    .out_total_bytes (total_bytes),
    .out_single_runs (single_runs),
    .out_pack_runs   (pack_runs)
  );

  // result packing
  assign out_tdata = {2'b00, pack_runs, single_runs, total_bytes, range_last, range_first};

endmodule

>>> dv/dmx_change_range_tracker_tb.sv
// self-checking testbench for the dmx change range tracker
module dmx_change_range_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dct_pkg::*;

  localparam int CH             = DCT_CHANNELS;
  localparam int HOLD           = DCT_ZERO_HOLD;
  localparam int STALL_LIMIT    = 5000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 8;
  localparam int SHORT_ITEMS    = 120;
  localparam int SHOW_MISMATCH  = 10;

  // how channel levels are drawn for a run of items
  typedef enum int {
    LV_QUIET,
    LV_BUSY,
    LV_SPARSE
  } level_mix_t;

  typedef struct packed {
    logic               range_valid;
    logic [CHAN_W-1:0]  range_first;
    logic [CHAN_W-1:0]  range_last;
    logic               frame_done;
    logic [TOTAL_W-1:0] total_bytes;
    logic [RUNS_W-1:0]  single_runs;
    logic [RUNS_W-1:0]  pack_runs;
  } range_report_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata    = 8'h00;  // [7:0] level
  logic              in_tuser    = 1'b0;   // [0] frame_start
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [OUT_DW-1:0] out_tdata;            // [8:0] range_first, [17:9] range_last,
                                           // [27:18] total_bytes, [36:28] single_runs,
                                           // [45:37] pack_runs
  logic              out_tuser;            // [0] range_valid
  logic              out_tlast;            // frame_done
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  // shadow of the channel memory and the frame scan
  logic [LEVEL_W-1:0] last_level [CH];
  bit                 chan_marked [CH];
  int                 hold_cnt [CH];
  int                 chan_pos;
  bit                 run_active;
  int                 run_first;
  int                 byte_cnt;
  int                 single_cnt;
  int                 pack_cnt;

  // shadow of the registers
  bit cfg_check_null = CHECK_NULL_RST;
  int cfg_first      = int'(WINDOW_FIRST_RST);
  int cfg_last       = int'(WINDOW_LAST_RST);

  range_report_t pending_ranges [$];

  int gap_pct;
  int stall_pct;
  int errors;
  int mismatches_shown;
  int items_sent;
  int results_checked;
  int frames_closed;
  int idle_cycles;

  dmx_change_range_tracker u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic string describe(range_report_t r);
    return $sformatf("valid=%0d first=%0d last=%0d done=%0d bytes=%0d singles=%0d packs=%0d",
                     r.range_valid, r.range_first, r.range_last, r.frame_done,
                     r.total_bytes, r.single_runs, r.pack_runs);
  endfunction

  function automatic void note_failure(string msg);
    errors++;
    if (mismatches_shown < SHOW_MISMATCH) begin
      mismatches_shown++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endfunction

  // close the open run at last_ch and fold it into the frame totals
  function automatic void close_run_at(input int last_ch, inout range_report_t rpt);
    int len;
    len = last_ch - run_first + 1;
    byte_cnt += len;
    if (len == 1) single_cnt++;
    else pack_cnt++;
    rpt.range_valid = 1'b1;
    rpt.range_first = run_first[CHAN_W-1:0];
    rpt.range_last  = last_ch[CHAN_W-1:0];
    run_active = 1'b0;
  endfunction

  // advance the shadow scan by one channel byte and queue the range it reports
  function automatic void track_channel(logic [LEVEL_W-1:0] lvl, logic fs);
    int ch;
    bit is_last;
    bit emitted;
    range_report_t rpt;
    ch = fs ? 0 : chan_pos;
    if (ch >= CH) ch = 0;
    if (ch == 0) begin
      run_active = 1'b0;
      run_first  = 0;
      byte_cnt   = 0;
      single_cnt = 0;
      pack_cnt   = 0;
    end
    if (ch + 1 >= cfg_first && ch + 1 <= cfg_last && last_level[ch] != lvl)
      chan_marked[ch] = 1'b1;
    last_level[ch] = lvl;
    // zero hold: count up while at zero, drop once held past the limit if check_null is set
    if (chan_marked[ch]) begin
      if (lvl != 0) hold_cnt[ch] = 0;
      else if (hold_cnt[ch] < HOLD) hold_cnt[ch]++;
      else if (cfg_check_null) chan_marked[ch] = 1'b0;
    end
    is_last = (ch == CH - 1);
    rpt     = '0;
    emitted = 1'b0;
    if (chan_marked[ch]) begin
      if (!run_active) begin
        run_active = 1'b1;
        run_first  = ch;
      end
      if (is_last) begin
        close_run_at(ch, rpt);
        emitted = 1'b1;
      end
    end else if (run_active) begin
      close_run_at(ch - 1, rpt);
      emitted = 1'b1;
    end
    chan_pos = is_last ? 0 : ch + 1;
    if (emitted || is_last) begin
      rpt.frame_done  = is_last;
      rpt.total_bytes = byte_cnt[TOTAL_W-1:0];
      rpt.single_runs = single_cnt[RUNS_W-1:0];
      rpt.pack_runs   = pack_cnt[RUNS_W-1:0];
      pending_ranges.push_back(rpt);
    end
  endfunction

  function automatic logic [LEVEL_W-1:0] pick_level(int ch, level_mix_t mix);
    int roll;
    roll = $urandom_range(99);
    case (mix)
      LV_QUIET: begin
        if (roll < 85) return '0;
        return LEVEL_W'($urandom_range(255));
      end
      LV_SPARSE: begin
        if (roll < 90) return last_level[ch];
        if (roll < 95) return '0;
        return LEVEL_W'($urandom_range(255));
      end
      default: begin
        if (roll < 30) return '0;
        if (roll < 60) return last_level[ch];
        if (roll < 70) return 8'hff;
        return LEVEL_W'($urandom_range(255));
      end
    endcase
  endfunction

  // offer one channel byte, with random gaps before it
  task automatic send_level(input logic [LEVEL_W-1:0] lvl, input logic fs);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= lvl;
    in_tuser  <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_channel(lvl, fs);
    items_sent++;
  endtask

  // stop sending and let every expected range come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_ranges.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write followed by a read back of the same register
  task automatic write_reg(input cfg_reg_t idx, input int value);
    logic [CFG_DW-1:0] rd;
    logic [CFG_DW-1:0] want;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_CHECK_NULL:   cfg_check_null = value[0];
      REG_WINDOW_FIRST: cfg_first      = value & 'h3ff;
      default:          cfg_last       = value & 'h3ff;
    endcase
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rd = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CHECK_NULL:   want = CFG_DW'(cfg_check_null);
      REG_WINDOW_FIRST: want = CFG_DW'(cfg_first);
      default:          want = CFG_DW'(cfg_last);
    endcase
    if (rd !== want)
      note_failure($sformatf("register %s read back %0d, expected %0d",
                             idx.name(), rd, want));
  endtask

  task automatic set_config(input int check_null, input int first, input int last);
    write_reg(REG_CHECK_NULL, check_null);
    write_reg(REG_WINDOW_FIRST, first);
    write_reg(REG_WINDOW_LAST, last);
  endtask

  // runs closing mid-frame, single and packed runs, frame start mid-frame
  task automatic test_basic_runs();
    send_level(8'hff, 1'b1);
    send_level(8'hff, 1'b0);
    send_level(8'h00, 1'b0);
    send_level(8'h01, 1'b0);
    send_level(8'h00, 1'b0);
    // restart while a run is open: its totals are discarded
    send_level(8'hff, 1'b1);
    send_level(8'h80, 1'b0);
    send_level(8'h00, 1'b1);
    send_level(8'h00, 1'b0);
    send_level(8'h00, 1'b0);
    send_level(8'h7f, 1'b0);
    send_level(8'h00, 1'b0);
  endtask

  // inverted, single-channel, zero-first and zero-last windows
  task automatic test_window_bounds();
    int firsts [4] = '{3, 2, 0, 1};
    int lasts  [4] = '{2, 2, 1, 0};
    for (int k = 0; k < 4; k++) begin
      drain();
      write_reg(REG_WINDOW_FIRST, firsts[k]);
      write_reg(REG_WINDOW_LAST, lasts[k]);
      for (int c = 0; c < 3; c++) send_level(~last_level[c], c == 0);
    end
  endtask

  // short frames, noise bursts, then one frame run out to its last channel
  task automatic test_random_phase(input int check_null, input int first, input int last);
    int sent;
    int len;
    int ch;
    logic fs;
    level_mix_t mix;
    drain();
    set_config(check_null, first, last);
    sent = 0;
    while (sent < SHORT_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        // noise: busy levels with rare stray frame starts
        len = $urandom_range(1, 20);
        repeat (len) begin
          fs = ($urandom_range(15) == 0);
          ch = fs ? 0 : chan_pos;
          send_level(pick_level(ch, LV_BUSY), fs);
        end
      end else begin
        // short frame; after a completed frame the start mark may be left off
        len = $urandom_range(2, 12);
        mix = ($urandom_range(9) < 6) ? LV_QUIET : LV_BUSY;
        fs  = !(chan_pos == 0 && $urandom_range(1) == 1);
        for (int c = 0; c < len; c++) send_level(pick_level(c, mix), (c == 0) ? fs : 1'b0);
      end
      sent += len;
    end
    // finish the current frame so that it closes with frame_done
    fs  = (chan_pos == 0);
    len = CH - chan_pos;
    for (int c = 0; c < len; c++)
      send_level(pick_level(chan_pos, LV_SPARSE), (c == 0) ? fs : 1'b0);
  endtask

  // random backpressure on the result side
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // compare each accepted result with the oldest expected range
  always @(posedge clk) begin : check_results
    range_report_t got;
    range_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.range_valid = out_tuser;
      got.range_first = out_tdata[8:0];
      got.range_last  = out_tdata[17:9];
      got.frame_done  = out_tlast;
      got.total_bytes = out_tdata[27:18];
      got.single_runs = out_tdata[36:28];
      got.pack_runs   = out_tdata[45:37];
      results_checked++;
      if (got.frame_done) frames_closed++;
      if (pending_ranges.size() == 0) begin
        note_failure($sformatf("result with nothing expected: %s", describe(got)));
      end else begin
        want = pending_ranges.pop_front();
        if (got !== want)
          note_failure($sformatf("expected %s, got %s", describe(want), describe(got)));
      end
    end
  end

  // watchdog on cycles where nothing moves
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable && cfg_pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing accepted for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int c = 0; c < CH; c++) begin
      last_level[c]  = '0;
      chan_marked[c] = 1'b0;
      hold_cnt[c]    = 0;
    end
    chan_pos         = 0;
    run_active       = 1'b0;
    run_first        = 0;
    byte_cnt         = 0;
    single_cnt       = 0;
    pack_cnt         = 0;
    errors           = 0;
    mismatches_shown = 0;
    items_sent       = 0;
    results_checked  = 0;
    frames_closed    = 0;
    idle_cycles      = 0;
    gap_pct          = 10;
    stall_pct        = 64;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_runs();
    test_window_bounds();
    test_random_phase(1, 1, 512);
    gap_pct   = 64;
    stall_pct = 10;
    test_random_phase(0, $urandom_range(1, 10), $urandom_range(5, 512));
    gap_pct   = 0;
    stall_pct = 0;
    test_random_phase(1, 0, 1023);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (pending_ranges.size() != 0)
      note_failure($sformatf("%0d expected ranges never arrived", pending_ranges.size()));
    $display("sent %0d channel items, checked %0d results over %0d closed frames",
             items_sent, results_checked, frames_closed);
    $display("windows covered: inverted, single channel, zero bounds, past the last channel");
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
